@@ rtl/core/ufi_pkg.sv @@
package ufi_pkg;

	// Default data width of the cell values and the face value.
	localparam int DATA_WIDTH_DEF = 32;

	// Field widths fixed by the interface.
	localparam int ORDER_W = 3;
	localparam int SIGN_W  = 2;

	// Stencil weights are over a common denominator of sixty.
	localparam int COEF_W = 7;

	// Half of the denominator, added to the magnitude for round half away from zero.
	localparam int ROUND_HALF = 30;

	// After the divide by four, the remaining divisor is fifteen (sixteen minus one).
	localparam int QUO_DIV = 15;
	localparam int DIGIT_W = 4;

	// Interpolation order codes; codes below order three act as order two.
	localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;
	localparam logic [ORDER_W-1:0] ORD_3       = 3'd3;
	localparam logic [ORDER_W-1:0] ORD_4       = 3'd4;
	localparam logic [ORDER_W-1:0] ORD_5       = 3'd5;
	localparam logic [ORDER_W-1:0] ORD_6       = 3'd6;
	localparam logic [ORDER_W-1:0] ORD_7       = 3'd7;

	// Upwind sign codes; both remaining codes mean a negative velocity.
	localparam logic [SIGN_W-1:0] SGN_ZERO = 2'b00;
	localparam logic [SIGN_W-1:0] SGN_POS  = 2'b01;

	// Weights applied to the nearest, middle and farthest pair sums.
	typedef struct packed {
		logic signed [COEF_W-1:0] c1;
		logic signed [COEF_W-1:0] c2;
		logic signed [COEF_W-1:0] c3;
	} coef_t;

	// Weights in sixtieths for each order and velocity sign.
	function automatic coef_t coef_f(input logic [ORDER_W-1:0] ord,
	                                 input logic [SIGN_W-1:0] sgn);
		coef_t c;
		logic  pos;
		logic  neg;
		pos = (sgn == SGN_POS);
		neg = (sgn != SGN_ZERO) && !pos;
		case (ord)
			ORD_3: begin
				c.c1 = pos ? COEF_W'(20)  : (neg ? COEF_W'(50)  : COEF_W'(35));
				c.c2 = pos ? COEF_W'(0)   : (neg ? COEF_W'(-10) : COEF_W'(-5));
				c.c3 = COEF_W'(0);
			end
			ORD_4: begin
				c.c1 = COEF_W'(35);
				c.c2 = COEF_W'(-5);
				c.c3 = COEF_W'(0);
			end
			ORD_5: begin
				c.c1 = pos ? COEF_W'(27) : (neg ? COEF_W'(47)  : COEF_W'(37));
				c.c2 = pos ? COEF_W'(-3) : (neg ? COEF_W'(-13) : COEF_W'(-8));
				c.c3 = pos ? COEF_W'(0)  : (neg ? COEF_W'(2)   : COEF_W'(1));
			end
			ORD_6, ORD_7: begin
				c.c1 = COEF_W'(37);
				c.c2 = COEF_W'(-8);
				c.c3 = COEF_W'(1);
			end
			default: begin
				c.c1 = COEF_W'(30);
				c.c2 = COEF_W'(0);
				c.c3 = COEF_W'(0);
			end
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/ufi_front.sv @@
module ufi_front import ufi_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic signed [DW-1:0]    cell_m3,
	input  logic signed [DW-1:0]    cell_m2,
	input  logic signed [DW-1:0]    cell_m1,
	input  logic signed [DW-1:0]    cell_p0,
	input  logic signed [DW-1:0]    cell_p1,
	input  logic signed [DW-1:0]    cell_p2,
	input  logic signed [DW-1:0]    bg_near,
	input  logic signed [DW-1:0]    bg_mid,
	input  logic signed [DW-1:0]    bg_far,
	input  logic [SIGN_W-1:0]       sign,
	input  logic [ORDER_W-1:0]      order,
	output logic                    out_vld,
	output logic [DW+6:0]           mag_q4,
	output logic                    neg
);

	// Pair sums need two guard bits; weighted sums stay below 2^(DW+7) in magnitude.
	localparam int SW  = DW + 2;
	localparam int PRW = DW + 9;

	logic signed [SW-1:0]  a1_s1, a2_s1, a3_s1;
	coef_t                 coef_s1;
	logic signed [PRW-1:0] p1_s2, p2_s2, p3_s2;
	logic signed [PRW-1:0] acc_s3;
	logic [PRW-3:0]        x_s4;
	logic                  neg_s4;
	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PRW-1:0]        rnd_mag;

	// Stage 1: symmetric pair sums less their background, and the weights.
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1   <= SW'(cell_m1) + SW'(cell_p0) - SW'(bg_near);
			a2_s1   <= SW'(cell_m2) + SW'(cell_p1) - SW'(bg_mid);
			a3_s1   <= SW'(cell_m3) + SW'(cell_p2) - SW'(bg_far);
			coef_s1 <= coef_f(order, sign);
		end
	end

	// Stage 2: one narrow multiply per pair.
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2 <= a1_s1 * $signed(coef_s1.c1);
			p2_s2 <= a2_s1 * $signed(coef_s1.c2);
			p3_s2 <= a3_s1 * $signed(coef_s1.c3);
		end
	end

	// Stage 3: numerator over sixty.
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s3 <= p1_s2 + p2_s2 + p3_s2;
		end
	end

	// Magnitude plus half the divisor; for a negative sum ~acc + 31 equals 30 - acc.
	assign rnd_mag = acc_s3[PRW-1] ? (~acc_s3 + PRW'(ROUND_HALF + 1))
	                               : (acc_s3 + PRW'(ROUND_HALF));

	// Stage 4: the divide by four is exact on the floor, so drop two bits here.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s4   <= rnd_mag[PRW-1:2];
			neg_s4 <= acc_s3[PRW-1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_vld = vld_s4;
	assign mag_q4  = x_s4;
	assign neg     = neg_s4;

endmodule

@@ rtl/core/ufi_div60.sv @@
module ufi_div60 import ufi_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [DW+6:0]        mag_q4,
	input  logic                 neg,
	output logic                 out_vld,
	output logic signed [DW-1:0] face_value,
	output logic                 saturated
);

	// The dividend is floor((|num| + 30) / 4); the quotient by fifteen is formed as
	// x * (2^K - 1) / 15 / 2^K, where (2^K - 1) / 15 = 0x1111... is built by doubling
	// the run of ones in each step: y += y << 4, y += y << 8, and so on.
	localparam int XW   = DW + 7;
	localparam int NDIG = (XW + DIGIT_W - 1) / DIGIT_W;
	localparam int J    = $clog2(NDIG);
	localparam int K    = DIGIT_W << J;
	localparam int PW   = XW + K;

	localparam logic [XW-1:0] MIN_MAG = XW'(1) << (DW - 1);
	localparam logic [DW-1:0] POS_LIM = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};

	logic [PW-1:0] prod_s [J];
	logic [XW-1:0] xv_s   [J];
	logic          neg_s  [J];
	logic          vld_s  [J];

	// Shift-add steps, one wide add each.
	for (genvar j = 0; j < J; j++) begin : g_step
		localparam int SH = DIGIT_W << j;
		logic [PW-1:0] src_prod;
		logic [XW-1:0] src_x;
		logic          src_neg;
		logic          src_vld;

		if (j == 0) begin : g_first
			assign src_prod = PW'(mag_q4);
			assign src_x    = mag_q4;
			assign src_neg  = neg;
			assign src_vld  = in_vld;
		end else begin : g_next
			assign src_prod = prod_s[j-1];
			assign src_x    = xv_s[j-1];
			assign src_neg  = neg_s[j-1];
			assign src_vld  = vld_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s[j] <= src_prod + (src_prod << SH);
				xv_s[j]   <= src_x;
				neg_s[j]  <= src_neg;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= src_vld;
			end
		end
	end

	logic [XW-1:0] q_est;
	logic [4:0]    fq_lo;
	logic [4:0]    rem_lo;
	logic [XW-1:0] quo_s1;
	logic          neg_q1_s1;
	logic          vld_q1_s1;

	// The estimate is low by at most one, so the remainder is below thirty and
	// its low five bits are exact.
	assign q_est  = prod_s[J-1][K +: XW];
	assign fq_lo  = {q_est[0], 4'b0000} - q_est[4:0];
	assign rem_lo = xv_s[J-1][4:0] - fq_lo;

	// Quotient correction stage.
	always_ff @(posedge clk) begin
		if (en) begin
			quo_s1    <= q_est + XW'(rem_lo >= 5'(QUO_DIV));
			neg_q1_s1 <= neg_s[J-1];
		end
	end

	logic          hi_nz;
	logic          sat_c;
	logic [DW-1:0] val_c;
	logic [DW-1:0] face_value_s2;
	logic          sat_s2;
	logic          vld_q2_s2;

	// Saturate against the signed range; the negative side reaches one further.
	assign hi_nz = |quo_s1[XW-1:DW-1];
	assign sat_c = hi_nz && !(neg_q1_s1 && (quo_s1 == MIN_MAG));
	assign val_c = sat_c ? (neg_q1_s1 ? NEG_LIM : POS_LIM)
	                     : (neg_q1_s1 ? (DW'(0) - quo_s1[DW-1:0]) : quo_s1[DW-1:0]);

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			face_value_s2 <= val_c;
			sat_s2        <= sat_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q1_s1 <= 1'b0;
			vld_q2_s2 <= 1'b0;
		end else if (en) begin
			vld_q1_s1 <= vld_s[J-1];
			vld_q2_s2 <= vld_q1_s1;
		end
	end

	assign out_vld    = vld_q2_s2;
	assign face_value = $signed(face_value_s2);
	assign saturated  = sat_s2;

endmodule

@@ rtl/core/upwind_face_interpolator.sv @@
// Channel   Handshake                  Beat
// in        in_valid / in_stall        six cells, three backgrounds, upwind_sign
// out       out_valid / out_stall      face_value, saturated
// cfg       cfg_valid / cfg_ready      interp_order
//
// One beat is accepted every cycle while in_stall is low; the pipeline is made of
// four front stages, the shift-add steps of the divide by sixty, and two output stages.
// Reset clears the valid bits, the skid valid bit and the order register (to order two).
// A stalled result freezes the whole pipeline; one input beat accepted in that
// cycle is held in a skid register, so in_stall is a register output.
module upwind_face_interpolator import ufi_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ORDER_W-1:0]           interp_order,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] cell_m3,
	input  logic signed [DATA_WIDTH-1:0] cell_m2,
	input  logic signed [DATA_WIDTH-1:0] cell_m1,
	input  logic signed [DATA_WIDTH-1:0] cell_p0,
	input  logic signed [DATA_WIDTH-1:0] cell_p1,
	input  logic signed [DATA_WIDTH-1:0] cell_p2,
	input  logic signed [DATA_WIDTH-1:0] bg_near,
	input  logic signed [DATA_WIDTH-1:0] bg_mid,
	input  logic signed [DATA_WIDTH-1:0] bg_far,
	input  logic signed [SIGN_W-1:0]     upwind_sign,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] face_value,
	output logic                         saturated
);

	localparam int DW = DATA_WIDTH;

	localparam logic signed [DW-1:0] POS_LIM = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};

	logic [ORDER_W-1:0] order_q;
	logic               en;

	// Order register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= interp_order;
		end
	end

	// The pipeline advances unless a finished result is held.
	assign en = !(out_valid && out_stall);

	logic                 skid_vld_q;
	logic signed [DW-1:0] sk_m3_q, sk_m2_q, sk_m1_q, sk_p0_q, sk_p1_q, sk_p2_q;
	logic signed [DW-1:0] sk_near_q, sk_mid_q, sk_far_q;
	logic [SIGN_W-1:0]    sk_sign_q;
	logic                 skid_load;

	assign in_stall  = skid_vld_q;
	assign skid_load = !skid_vld_q && in_valid && !en;

	// Skid register: catches the beat accepted while the pipeline is frozen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_load) begin
			skid_vld_q <= 1'b1;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_load) begin
			sk_m3_q   <= cell_m3;
			sk_m2_q   <= cell_m2;
			sk_m1_q   <= cell_m1;
			sk_p0_q   <= cell_p0;
			sk_p1_q   <= cell_p1;
			sk_p2_q   <= cell_p2;
			sk_near_q <= bg_near;
			sk_mid_q  <= bg_mid;
			sk_far_q  <= bg_far;
			sk_sign_q <= upwind_sign;
		end
	end

	logic          fr_vld;
	logic [DW+6:0] mag_q4;
	logic          mag_neg;
	logic          fr_out_vld;

	assign fr_vld = skid_vld_q || in_valid;

	ufi_front #(.DW(DW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (fr_vld),
		.cell_m3 (skid_vld_q ? sk_m3_q   : cell_m3),
		.cell_m2 (skid_vld_q ? sk_m2_q   : cell_m2),
		.cell_m1 (skid_vld_q ? sk_m1_q   : cell_m1),
		.cell_p0 (skid_vld_q ? sk_p0_q   : cell_p0),
		.cell_p1 (skid_vld_q ? sk_p1_q   : cell_p1),
		.cell_p2 (skid_vld_q ? sk_p2_q   : cell_p2),
		.bg_near (skid_vld_q ? sk_near_q : bg_near),
		.bg_mid  (skid_vld_q ? sk_mid_q  : bg_mid),
		.bg_far  (skid_vld_q ? sk_far_q  : bg_far),
		.sign    (skid_vld_q ? sk_sign_q : upwind_sign),
		.order   (order_q),
		.out_vld (fr_out_vld),
		.mag_q4  (mag_q4),
		.neg     (mag_neg)
	);

	ufi_div60 #(.DW(DW)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (fr_out_vld),
		.mag_q4     (mag_q4),
		.neg        (mag_neg),
		.out_vld    (out_valid),
		.face_value (face_value),
		.saturated  (saturated)
	);

	// A saturated result is always one of the two range limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> face_value == POS_LIM || face_value == NEG_LIM)
		else $error("saturated result is not a range limit");

	// The skid register drains as soon as the pipeline moves.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && en |=> !skid_vld_q)
		else $error("skid register did not drain");

	// A beat accepted while the pipeline is frozen lands in the skid register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !en |=> skid_vld_q)
		else $error("beat accepted during a freeze was dropped");

endmodule
